FILE: rtl/core/aes_pkg.sv
// AES-128 package: block and round-key types, S-box table, round and key-schedule functions.
// No dependencies; imported by the round stage, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package aes_pkg;

  localparam int unsigned BLK_W   = 128;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned NUM_RND = 10;

  // configuration register indexes
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  typedef struct packed {
    logic [BLK_W-1:0] state;
    logic [BLK_W-1:0] rkey;
  } aes_blk_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] RCON [0:NUM_RND-1] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] aes_xtime(input logic [7:0] v);
    aes_xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of a block sits at bits [127-8k -: 8]
  function automatic logic [BLK_W-1:0] aes_sub_shift(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BLK_W-1-8*(4*c+r) -: 8] = SBOX[s[BLK_W-1-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [BLK_W-1:0] aes_mix_cols(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = s[BLK_W-1-32*c -: 8];
      a1  = s[BLK_W-9-32*c -: 8];
      a2  = s[BLK_W-17-32*c -: 8];
      a3  = s[BLK_W-25-32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[BLK_W-1-32*c -: 8]  = a0 ^ all ^ aes_xtime(a0 ^ a1);
      t[BLK_W-9-32*c -: 8]  = a1 ^ all ^ aes_xtime(a1 ^ a2);
      t[BLK_W-17-32*c -: 8] = a2 ^ all ^ aes_xtime(a2 ^ a3);
      t[BLK_W-25-32*c -: 8] = a3 ^ all ^ aes_xtime(a3 ^ a0);
    end
    return t;
  endfunction

  function automatic logic [BLK_W-1:0] aes_key_next(input logic [BLK_W-1:0] rk,
                                                    input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, tw, n0, n1, n2, n3;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    tw = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    n0 = w0 ^ tw;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/aes128_block_encrypt_unit.sv
// AES-128 block encryption, top level: key registers, initial AddRoundKey stage, ten round stages.
// Depends on aes_pkg and aes_rnd_stage.
//
//  channel | direction | handshake          | payload
//  in_     | in        | in_tvalid/tready   | tdata[63:0] plain_high, [127:64] plain_low
//  out_    | out       | out_tvalid/tready  | tdata[63:0] cipher_high, [127:64] cipher_low
//  cfg_    | in        | cfg_we             | cfg_addr 0 key_high, 1 key_low; cfg_wdata
//
// One item per cycle while the output is not stalled; each item passes the AddRoundKey stage and
// ten round stages, and the round key is expanded alongside the data in each round stage.
// Synchronous active-low reset clears stage valids and the key to zero.
// Each stage holds its item under backpressure; empty stages fill while the output stalls.
`timescale 1ns / 1ps
`default_nettype none

module aes128_block_encrypt_unit
  import aes_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [BLK_W-1:0]   in_tdata,   // plain_high, plain_low
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [BLK_W-1:0]        out_tdata,  // cipher_high, cipher_low
  input  wire logic               cfg_we,
  input  wire logic               cfg_addr,
  input  wire logic [HALF_W-1:0]  cfg_wdata
);

  logic [HALF_W-1:0] key_high_r;
  logic [HALF_W-1:0] key_low_r;
  logic              v0_r;
  aes_blk_t          blk0_r;
  logic [BLK_W-1:0]  key;
  logic [BLK_W-1:0]  plain;

  logic     st_valid [0:NUM_RND];
  logic     st_ready [0:NUM_RND];
  aes_blk_t st_blk   [0:NUM_RND];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KEY_HIGH: key_high_r <= cfg_wdata;
        REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign key   = {key_high_r, key_low_r};
  assign plain = {in_tdata[HALF_W-1:0], in_tdata[BLK_W-1:HALF_W]};

  assign in_tready = !v0_r || st_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_tready) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      blk0_r.state <= plain ^ key;
      blk0_r.rkey  <= key;
    end
  end

  assign st_valid[0] = v0_r;
  assign st_blk[0]   = blk0_r;

  for (genvar i = 0; i < NUM_RND; i++) begin : g_rnd
    aes_rnd_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[i]),
      .up_ready (st_ready[i]),
      .up_blk   (st_blk[i]),
      .rcon     (RCON[i]),
      .last_rnd (i == NUM_RND - 1),
      .dn_valid (st_valid[i+1]),
      .dn_ready (st_ready[i+1]),
      .dn_blk   (st_blk[i+1])
    );
  end

  assign st_ready[NUM_RND] = out_tready;
  assign out_tvalid        = st_valid[NUM_RND];
  assign out_tdata         = {st_blk[NUM_RND].state[HALF_W-1:0],
                              st_blk[NUM_RND].state[BLK_W-1:HALF_W]};

endmodule

`default_nettype wire

FILE: rtl/core/aes_rnd_stage.sv
// AES round stage: key schedule step, SubBytes/ShiftRows, MixColumns (not last round), AddRoundKey.
// Depends on aes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aes_rnd_stage
  import aes_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     up_valid,
  output logic          up_ready,
  input  wire aes_blk_t up_blk,
  input  wire logic [7:0] rcon,
  input  wire logic     last_rnd,
  output logic          dn_valid,
  input  wire logic     dn_ready,
  output aes_blk_t      dn_blk
);

  logic             valid_r;
  aes_blk_t         blk_r;
  aes_blk_t         blk_nxt;
  logic [BLK_W-1:0] ss;
  logic [BLK_W-1:0] mc;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    blk_nxt.rkey  = aes_key_next(up_blk.rkey, rcon);
    ss            = aes_sub_shift(up_blk.state);
    mc            = last_rnd ? ss : aes_mix_cols(ss);
    blk_nxt.state = mc ^ blk_nxt.rkey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      blk_r <= blk_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_blk   = blk_r;

endmodule

`default_nettype wire

FILE: rtl/core/aes_chk.sv
// Port-level checker for the AES-128 unit, attached by bind.
// Depends on aes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aes_chk
  import aes_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic [BLK_W-1:0]  in_tdata,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [BLK_W-1:0]  out_tdata,
  input wire logic              cfg_we,
  input wire logic              cfg_addr,
  input wire logic [HALF_W-1:0] cfg_wdata
);

  localparam int unsigned DEPTH = NUM_RND + 1;

  logic [3:0] cnt_r;
  logic [3:0] cnt_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign cnt_nxt = cnt_r + {3'b000, in_acc} - {3'b000, out_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != 4'd0)
    else $error("result with no item in flight");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 4'(DEPTH))
    else $error("more items in flight than stages");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is ready");

  // unused payload ports kept for bind by name
  logic unused_ok;
  assign unused_ok = ^{in_tdata, cfg_we, cfg_addr, cfg_wdata};

endmodule

bind aes128_block_encrypt_unit aes_chk u_aes_chk (.*);

`default_nettype wire
